// ===== design/rc4_pkg.sv =====
// Shared types and constants for the RC4 stream cipher engine.
`default_nettype none

package rc4_pkg;

    // byte-wide datapath and the permutation table size
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned TABLE_DEPTH = 256;

    // default maximum key length in bytes
    localparam int unsigned KEY_MAX_DEF = 256;

    typedef logic [BYTE_W-1:0] byte_t;

    // word kind carried on tuser
    localparam logic FUNC_KEY  = 1'b0;
    localparam logic FUNC_DATA = 1'b1;

    // controller state codes
    localparam int unsigned ST_W = 4;
    localparam logic [ST_W-1:0] ST_IDLE    = 4'd0;
    localparam logic [ST_W-1:0] ST_RD_I    = 4'd1;
    localparam logic [ST_W-1:0] ST_RD_J    = 4'd2;
    localparam logic [ST_W-1:0] ST_WB      = 4'd3;
    localparam logic [ST_W-1:0] ST_KS_INIT = 4'd4;
    localparam logic [ST_W-1:0] ST_KS_RD   = 4'd5;
    localparam logic [ST_W-1:0] ST_KS_ACC  = 4'd6;
    localparam logic [ST_W-1:0] ST_KS_WR   = 4'd7;
    localparam logic [ST_W-1:0] ST_KS_FIN  = 4'd8;

endpackage

`default_nettype wire

// ===== design/rc4_stream_cipher.sv =====
// RC4 stream cipher engine: key store, key schedule and keystream generator.
`default_nettype none

// RC4 engine around a 256 x 8 permutation RAM (one write and one read port, registered read
// output) and a key RAM of KEY_MAX bytes. Input words carry the kind on s_tuser (0 = key
// byte, 1 = data byte) and the last mark on s_tlast. Key bytes are stored as they are accepted
// and give no output; bytes beyond KEY_MAX are dropped. A key byte with tlast set starts the
// key schedule: ST_KS_INIT, then ST_KS_RD, ST_KS_ACC and ST_KS_WR for each of the 256 swaps,
// then ST_KS_FIN; s_tready stays low meanwhile. Each data byte yields one output word, byte
// XOR keystream, with tlast copied. A data byte passes through ST_RD_I, ST_RD_J and ST_WB:
// the dependent reads of S[i], S[j] and S[S[i]+S[j]] each wait on the RAM, and the final
// swap write overlaps the next accept. Encryption and decryption are the same operation.
// After reset the table is the identity permutation with i = j = 0; this is held by per-entry
// valid bits, so no clearing pass is needed and the block is ready right after reset.
module rc4_stream_cipher #(
    parameter int unsigned KEY_MAX = rc4_pkg::KEY_MAX_DEF
) (
    input  wire        aclk,
    input  wire        aresetn,
    // input words
    input  wire        s_tvalid,
    output logic       s_tready,
    input  wire  [7:0] s_tdata,   // [7:0] byte_in
    input  wire        s_tuser,   // [0] func
    input  wire        s_tlast,   // last_item
    // result words
    output logic       m_tvalid,
    input  wire        m_tready,
    output logic [7:0] m_tdata,   // [7:0] byte_out
    output logic       m_tlast    // last_out
);

    import rc4_pkg::*;

    localparam int unsigned KEY_AW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
    localparam int unsigned KEY_CW = $clog2(KEY_MAX + 1);

    // control and pointer registers
    logic [ST_W-1:0]   state_reg, state_next;
    byte_t             i_reg, i_next;         // ptr_i, or swap index n in the schedule
    byte_t             j_reg, j_next;         // ptr_j, or accumulator in the schedule
    byte_t             si_reg, si_next;       // S[i] (or S[n]) held for the swap
    byte_t             t_reg, t_next;         // keystream table index
    logic [KEY_CW-1:0] key_count_reg, key_count_next;
    logic [KEY_CW-1:0] k_reg, k_next;         // cyclic key index in the schedule
    logic              pend_reg, pend_next;   // schedule swap write still owed
    byte_t             data_reg;
    logic              dlast_reg;
    logic              data_load;

    // output register
    logic  m_tvalid_reg, m_tvalid_next;
    byte_t m_tdata_reg;
    logic  m_tlast_reg;
    logic  out_load;
    byte_t out_byte;
    logic  out_free;

    // permutation RAM with valid bits and write-to-read forwarding
    byte_t                  perm_ram_reg [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] perm_vld_reg;
    logic                   vld_clear;
    byte_t                  rd_addr;
    byte_t                  wr_addr;
    byte_t                  wr_data;
    logic                   wr_en;
    byte_t                  perm_q_reg;
    logic                   vld_q_reg;
    byte_t                  addr_q_reg;
    logic                   fwd_hit_reg;
    byte_t                  fwd_data_reg;
    byte_t                  rd_eff;

    // key RAM
    byte_t              key_ram_reg [KEY_MAX];
    logic               key_we;
    logic [KEY_AW-1:0]  key_wr_addr;
    byte_t              key_q_reg;

    logic  s_accept;
    byte_t ks_byte;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) || ((state_reg == ST_WB) && out_free);
    assign s_accept = s_tvalid && s_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // effective read data: pending write first, then stored entry, then identity
    assign rd_eff  = fwd_hit_reg ? fwd_data_reg : (vld_q_reg ? perm_q_reg : addr_q_reg);
    // the S[j] write is still in flight while the keystream read lands
    assign ks_byte = (t_reg == j_reg) ? si_reg : rd_eff;
    assign out_byte = data_reg ^ ks_byte;
    assign key_wr_addr = key_count_reg[KEY_AW-1:0];

    // next-state and datapath control
    always_comb begin
        state_next     = state_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        si_next        = si_reg;
        t_next         = t_reg;
        key_count_next = key_count_reg;
        k_next         = k_reg;
        pend_next      = pend_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        out_load       = 1'b0;
        data_load      = 1'b0;
        rd_addr        = t_reg;
        wr_en          = 1'b0;
        wr_addr        = i_reg;
        wr_data        = si_reg;
        key_we         = 1'b0;
        vld_clear      = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
            end
            ST_RD_I: begin
                // S[i] arrives: step j and fetch S[j]
                si_next    = rd_eff;
                j_next     = byte_t'(j_reg + rd_eff);
                rd_addr    = j_next;
                state_next = ST_RD_J;
            end
            ST_RD_J: begin
                // S[j] arrives: S[i] <= S[j], fetch S[S[i]+S[j]]
                wr_en      = 1'b1;
                wr_addr    = i_reg;
                wr_data    = rd_eff;
                t_next     = byte_t'(si_reg + rd_eff);
                rd_addr    = t_next;
                state_next = ST_WB;
            end
            ST_WB: begin
                // S[j] <= old S[i], emit the output word
                wr_en   = 1'b1;
                wr_addr = j_reg;
                wr_data = si_reg;
                rd_addr = t_reg;
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    out_load      = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_KS_INIT: begin
                vld_clear  = 1'b1;
                i_next     = '0;
                j_next     = '0;
                k_next     = '0;
                pend_next  = 1'b0;
                state_next = ST_KS_RD;
            end
            ST_KS_RD: begin
                // finish the previous swap, fetch S[n] and key[k]
                wr_en      = pend_reg;
                wr_addr    = j_reg;
                wr_data    = si_reg;
                rd_addr    = i_reg;
                state_next = ST_KS_ACC;
            end
            ST_KS_ACC: begin
                si_next    = rd_eff;
                j_next     = byte_t'(j_reg + rd_eff + key_q_reg);
                rd_addr    = j_next;
                state_next = ST_KS_WR;
            end
            ST_KS_WR: begin
                // S[n] <= S[acc]; S[acc] is written on the next pass
                wr_en     = 1'b1;
                wr_addr   = i_reg;
                wr_data   = rd_eff;
                pend_next = 1'b1;
                k_next    = (KEY_CW'(k_reg + 1'b1) == key_count_reg) ? '0
                                                                     : KEY_CW'(k_reg + 1'b1);
                i_next    = byte_t'(i_reg + 1'b1);
                state_next = (i_reg == byte_t'(TABLE_DEPTH - 1)) ? ST_KS_FIN : ST_KS_RD;
            end
            ST_KS_FIN: begin
                wr_en          = 1'b1;
                wr_addr        = j_reg;
                wr_data        = si_reg;
                pend_next      = 1'b0;
                i_next         = '0;
                j_next         = '0;
                key_count_next = '0;
                state_next     = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // accepted input word
        if (s_accept) begin
            if (s_tuser == FUNC_DATA) begin
                i_next     = byte_t'(i_reg + 1'b1);
                rd_addr    = i_next;
                data_load  = 1'b1;
                state_next = ST_RD_I;
            end else begin
                if (key_count_reg < KEY_CW'(KEY_MAX)) begin
                    key_we         = 1'b1;
                    key_count_next = KEY_CW'(key_count_reg + 1'b1);
                end
                state_next = s_tlast ? ST_KS_INIT : ST_IDLE;
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            key_count_reg <= '0;
            k_reg         <= '0;
            pend_reg      <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            perm_vld_reg  <= '0;
        end else begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            key_count_reg <= key_count_next;
            k_reg         <= k_next;
            pend_reg      <= pend_next;
            m_tvalid_reg  <= m_tvalid_next;
            if (vld_clear) begin
                perm_vld_reg <= '0;
            end else if (wr_en) begin
                perm_vld_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        si_reg <= si_next;
        t_reg  <= t_next;
        if (data_load) begin
            data_reg  <= s_tdata;
            dlast_reg <= s_tlast;
        end
        if (out_load) begin
            m_tdata_reg <= out_byte;
            m_tlast_reg <= dlast_reg;
        end
    end

    // permutation RAM
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            perm_ram_reg[wr_addr] <= wr_data;
        end
        perm_q_reg   <= perm_ram_reg[rd_addr];
        vld_q_reg    <= perm_vld_reg[rd_addr];
        addr_q_reg   <= rd_addr;
        fwd_hit_reg  <= wr_en && (wr_addr == rd_addr);
        fwd_data_reg <= wr_data;
    end

    // key RAM
    always_ff @(posedge aclk) begin
        if (key_we) begin
            key_ram_reg[key_wr_addr] <= s_tdata;
        end
        key_q_reg <= key_ram_reg[k_reg[KEY_AW-1:0]];
    end

    // checks
    a_out_from_wb: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == ST_WB))
        else $error("output word raised outside write-back");

    a_busy_in_sched: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_KS_INIT || state_reg == ST_KS_RD || state_reg == ST_KS_ACC ||
         state_reg == ST_KS_WR || state_reg == ST_KS_FIN) |-> !s_tready)
        else $error("input accepted during key schedule");

    a_sched_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_KS_FIN) |=> (i_reg == '0 && j_reg == '0 && key_count_reg == '0))
        else $error("pointers or key count not cleared after schedule");

    a_key_count: assert property (@(posedge aclk) disable iff (!aresetn)
        key_count_reg <= KEY_CW'(KEY_MAX))
        else $error("key count beyond maximum");

endmodule

`default_nettype wire

// ===== dv/rc4_stream_checker.sv =====
// Scoreboard for the RC4 engine: tracks the cipher state and checks every output word.
module rc4_stream_checker #(
    parameter int unsigned KEY_LIMIT = rc4_pkg::KEY_MAX_DEF
) (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_tvalid,
    input  wire        s_tready,
    input  wire  [7:0] s_tdata,   // [7:0] byte_in
    input  wire        s_tuser,   // [0] func
    input  wire        s_tlast,   // last_item
    input  wire        m_tvalid,
    input  wire        m_tready,
    input  wire  [7:0] m_tdata,   // [7:0] byte_out
    input  wire        m_tlast,   // last_out
    output int         fail_count,
    output int         pending
);
    import rc4_pkg::*;

    typedef struct packed {
        byte_t text;
        logic  last;
    } cipher_word_t;

    // shadow cipher state
    byte_t        sbox    [TABLE_DEPTH];
    byte_t        key_mem [TABLE_DEPTH];
    byte_t        idx_i;
    byte_t        idx_j;
    int unsigned  key_len;

    // cipher words still owed by the block, oldest first
    cipher_word_t cipher_q [$];
    cipher_word_t owed;

    int n_fail = 0;
    int n_owed = 0;

    assign fail_count = n_fail;
    assign pending    = n_owed;

    task automatic note_mismatch(input string what, input int want, input int got);
        n_fail++;
        if (n_fail <= 10)
            $display("%0t: %s mismatch: expected %02h, got %02h", $time, what, want, got);
    endtask

    // key schedule over the bytes loaded so far
    task automatic schedule_key();
        int unsigned n;
        byte_t acc;
        byte_t held;
        byte_t kb;
        for (n = 0; n < TABLE_DEPTH; n++)
            sbox[n] = byte_t'(n);
        acc = '0;
        for (n = 0; n < TABLE_DEPTH; n++) begin
            kb      = (key_len != 0) ? key_mem[n % key_len] : '0;
            acc     = acc + sbox[n] + kb;
            held    = sbox[n];
            sbox[n] = sbox[acc];
            sbox[acc] = held;
        end
        idx_i   = '0;
        idx_j   = '0;
        key_len = 0;
    endtask

    // one step of the keystream generator
    function automatic byte_t keystream_byte();
        byte_t held;
        byte_t t;
        idx_i       = idx_i + 8'd1;
        idx_j       = idx_j + sbox[idx_i];
        held        = sbox[idx_i];
        sbox[idx_i] = sbox[idx_j];
        sbox[idx_j] = held;
        t           = sbox[idx_i] + sbox[idx_j];
        return sbox[t];
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int n = 0; n < TABLE_DEPTH; n++)
                sbox[n] = byte_t'(n);
            idx_i   = '0;
            idx_j   = '0;
            key_len = 0;
            cipher_q.delete();
        end else begin
            // output side first: a word leaving now never belongs to a word entering now
            if (m_tvalid && m_tready) begin
                if (cipher_q.size() == 0) begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("%0t: unexpected output word %02h last %0b",
                                 $time, m_tdata, m_tlast);
                end else begin
                    owed = cipher_q.pop_front();
                    if (m_tdata !== owed.text)
                        note_mismatch("byte_out", owed.text, m_tdata);
                    if (m_tlast !== owed.last)
                        note_mismatch("last_out", owed.last, m_tlast);
                end
            end
            // input side
            if (s_tvalid && s_tready) begin
                if (s_tuser == FUNC_KEY) begin
                    // bytes past the key limit are dropped
                    if (key_len < KEY_LIMIT) begin
                        key_mem[key_len] = s_tdata;
                        key_len++;
                    end
                    if (s_tlast)
                        schedule_key();
                end else begin
                    owed.text = s_tdata ^ keystream_byte();
                    owed.last = s_tlast;
                    cipher_q.push_back(owed);
                end
            end
        end
        n_owed = cipher_q.size();
    end

endmodule

// ===== dv/rc4_stream_cipher_tb.sv =====
// Testbench top for the RC4 engine: clock, reset, input and output traffic, verdict.
module rc4_stream_cipher_tb;
    import rc4_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    // a key schedule is the longest stretch without output
    localparam int unsigned DRAIN_CYCLES = 3 * TABLE_DEPTH + 32;
    localparam int unsigned PHASE_WORDS  = 65;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic [7:0] s_tdata  = '0;
    logic       s_tuser  = FUNC_KEY;
    logic       s_tlast  = 1'b0;
    logic       m_tready = 1'b0;
    wire        s_tready;
    wire        m_tvalid;
    wire  [7:0] m_tdata;
    wire        m_tlast;

    int          fail_count;
    int          pending;
    int unsigned send_idle_pct = 36;
    int unsigned recv_idle_pct = 74;
    int unsigned n_sent        = 0;
    longint      cycles        = 0;

    always #5 aclk = ~aclk;

    rc4_stream_cipher uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    rc4_stream_checker chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // output side back-pressure
    always @(negedge aclk) begin
        m_tready <= aresetn && ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("** rc4_stream_cipher: FAILED **");
            $finish;
        end
    end

    // present one input word; entered and left at a falling edge
    task automatic push_word(input logic func, input byte_t b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    function automatic byte_t any_byte();
        return byte_t'($urandom_range(255));
    endfunction

    // full key load, optionally with data words mixed in before the schedule runs
    task automatic send_key(input int unsigned len, input bit mix_data);
        for (int unsigned k = 0; k < len; k++) begin
            if (mix_data && $urandom_range(3) == 0) begin
                push_word(FUNC_DATA, any_byte(), logic'($urandom_range(1)));
                n_sent++;
            end
            push_word(FUNC_KEY, any_byte(), k == len - 1);
            if (k < KEY_MAX_DEF)
                n_sent++;
        end
    endtask

    // data burst with last marks set at random
    task automatic send_data(input int unsigned len);
        logic last;
        for (int unsigned k = 0; k < len; k++) begin
            last = (k == len - 1) ? logic'($urandom_range(1)) : ($urandom_range(9) == 0);
            push_word(FUNC_DATA, any_byte(), last);
            n_sent++;
        end
    endtask

    task automatic random_phase(input int unsigned words);
        int unsigned pick;
        int unsigned len;
        n_sent = 0;
        while (n_sent < words) begin
            pick = $urandom_range(99);
            if (pick < 15) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
                send_key(len, $urandom_range(3) == 0);
            end else if (pick < 22) begin
                // stray word of any kind
                push_word(logic'($urandom_range(1)), any_byte(), logic'($urandom_range(1)));
                n_sent++;
            end else begin
                send_data($urandom_range(1, 24));
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // keystream straight from reset, before any key
        push_word(FUNC_DATA, 8'h00, 1'b0);
        push_word(FUNC_DATA, 8'hFF, 1'b1);
        // shortest key, all zero
        push_word(FUNC_KEY,  8'h00, 1'b1);
        push_word(FUNC_DATA, 8'hFF, 1'b0);
        push_word(FUNC_DATA, 8'h80, 1'b1);
        // data during a key load still runs on the old table
        push_word(FUNC_KEY,  8'hFF, 1'b0);
        push_word(FUNC_DATA, 8'h55, 1'b0);
        push_word(FUNC_KEY,  8'h01, 1'b0);
        push_word(FUNC_DATA, 8'hAA, 1'b1);
        push_word(FUNC_KEY,  8'h7F, 1'b1);
        push_word(FUNC_DATA, 8'h00, 1'b0);
        push_word(FUNC_DATA, 8'h01, 1'b0);
        push_word(FUNC_DATA, 8'hFE, 1'b0);
        push_word(FUNC_DATA, 8'hFF, 1'b1);
        push_word(FUNC_KEY,  8'hFF, 1'b1);
        push_word(FUNC_DATA, 8'h3C, 1'b1);

        random_phase(PHASE_WORDS);

        send_idle_pct = 74;
        recv_idle_pct = 36;
        random_phase(PHASE_WORDS);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(PHASE_WORDS);
        // key longer than the store, then data on the resulting table
        send_key(KEY_MAX_DEF + $urandom_range(1, 12), 1'b0);
        send_data(20);

        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("** rc4_stream_cipher: PASSED **");
        else
            $display("** rc4_stream_cipher: FAILED **");
        $finish;
    end

endmodule
